// ===== design/sbfe_pkg.sv =====
// Shared types and constants for the seven-bit frame encoder.
// Used by sbfe_front, sbfe_queue, sbfe_back and seven_bit_frame_encoder; no dependencies.
package sbfe_pkg;

  localparam int unsigned MaxPayload = 99;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QAw        = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw        = $clog2(QDepth + 1);

  localparam logic [7:0] StartByte  = 8'h80;
  localparam logic [7:0] CloseByte  = 8'hFF;
  localparam logic [7:0] HeaderBase = 8'd13;

  // floor(x / 7) for x below 1024 as (x * Recip7) >> Recip7Shift
  localparam logic [11:0] Recip7      = 12'd2341;
  localparam int unsigned Recip7Shift = 14;

  // last result index of a header run, without and with the closing byte
  localparam logic [3:0] HdrLastIdx  = 4'd11;
  localparam logic [3:0] HdrCloseIdx = 4'd12;

  typedef enum logic [1:0] {
    JobReject = 2'd0,
    JobHeader = 2'd1,
    JobData   = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [28:0] to_addr;
    logic [27:0] from_addr;
    logic [13:0] msg_type;
    logic [7:0]  len_byte;
    logic [6:0]  grp0;
    logic [6:0]  grp1;
    logic        two_grp;
    logic        close;
    logic [3:0]  last_idx;
  } job_t;

endpackage

// ===== design/sbfe_front.sv =====
// Front end: accepts items, checks them against the frame state and packs payload bits.
// Depends on sbfe_pkg; pushes one job per accepted item into sbfe_queue.
module sbfe_front import sbfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [27:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic        mode_i,
  input  logic [28:0] to_address_i,
  input  logic [13:0] message_type_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  data_byte_i,
  output job_t        job_o
);

  logic [27:0] local_addr_q;
  logic [5:0]  carry_q, carry_d;
  logic [2:0]  count_q, count_d;
  logic [6:0]  left_q, left_d;
  logic        open_q, open_d;

  logic [13:0] sum;
  logic [3:0]  cnt;
  logic        two;
  logic        last;
  logic [10:0] len_num;
  logic [22:0] len_prod;
  logic [7:0]  len_byte;

  assign sum      = 14'(carry_q) | (14'(data_byte_i) << count_q);
  assign cnt      = 4'(count_q) + 4'd8;
  assign two      = (cnt == 4'd14);
  assign last     = (left_q == 7'd1);
  assign len_num  = {payload_length_i, 3'b000} + 11'd6;
  assign len_prod = 23'(len_num) * 23'(Recip7);
  assign len_byte = HeaderBase + 8'(len_prod >> Recip7Shift);

  always_comb begin
    carry_d         = carry_q;
    count_d         = count_q;
    left_d          = left_q;
    open_d          = open_q;
    job_o           = '0;
    job_o.kind      = JobReject;
    job_o.to_addr   = to_address_i;
    job_o.from_addr = local_addr_q;
    job_o.msg_type  = message_type_i;
    job_o.len_byte  = len_byte;
    job_o.grp0      = sum[6:0];
    job_o.grp1      = sum[13:7];
    if (!mode_i) begin
      if (payload_length_i > 8'(MaxPayload)) begin
        job_o.kind = JobReject;
      end else begin
        job_o.kind     = JobHeader;
        job_o.close    = (payload_length_i == 8'd0);
        job_o.last_idx = job_o.close ? HdrCloseIdx : HdrLastIdx;
        carry_d        = '0;
        count_d        = '0;
        left_d         = payload_length_i[6:0];
        open_d         = (payload_length_i != 8'd0);
      end
    end else if (open_q && (left_q != 7'd0)) begin
      job_o.kind     = JobData;
      job_o.two_grp  = two || last;
      job_o.close    = last;
      job_o.last_idx = 4'(job_o.two_grp) + 4'(job_o.close);
      left_d         = left_q - 7'd1;
      // flush the partial group on the last byte, else keep the leftover bits
      if (two || last) begin
        carry_d = '0;
        count_d = '0;
      end else begin
        carry_d = sum[12:7];
        count_d = 3'(cnt - 4'd7);
      end
      if (last) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      carry_q      <= '0;
      count_q      <= '0;
      left_q       <= '0;
      open_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        local_addr_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        carry_q <= carry_d;
        count_q <= count_d;
        left_q  <= left_d;
        open_q  <= open_d;
      end
    end
  end

endmodule

// ===== design/sbfe_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on sbfe_pkg for job_t and the queue depth.
module sbfe_queue import sbfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QCw-1:0] count_q;

  assign full_o  = (count_q == QCw'(QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QAw'(QDepth - 1)) ? '0 : wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QAw'(QDepth - 1)) ? '0 : rd_q + QAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCw'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCw'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full job queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty job queue");

endmodule

// ===== design/sbfe_back.sv =====
// Byte sequencer: turns the queue head job into frame bytes, one per unstalled cycle.
// Depends on sbfe_pkg; drives the registered output channel.
module sbfe_back import sbfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_frame_o,
  output logic       rejected_o
);

  logic [3:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, eof_q, rej_q;

  logic       fire;
  logic       at_last;
  logic [7:0] byte_d;
  logic       eof_d, rej_d;

  assign fire    = !empty_i && (!valid_q || !out_stall_i);
  assign at_last = (idx_q == job_i.last_idx);
  assign pop_o   = fire && at_last;

  always_comb begin
    byte_d = CloseByte;
    eof_d  = 1'b0;
    rej_d  = 1'b0;
    unique case (job_i.kind)
      JobHeader: begin
        unique case (idx_q)
          4'd0:    byte_d = StartByte | 8'(job_i.to_addr[28]);
          4'd1:    byte_d = {1'b0, job_i.to_addr[27:21]};
          4'd2:    byte_d = {1'b0, job_i.to_addr[20:14]};
          4'd3:    byte_d = {1'b0, job_i.to_addr[13:7]};
          4'd4:    byte_d = {1'b0, job_i.to_addr[6:0]};
          4'd5:    byte_d = {1'b0, job_i.from_addr[27:21]};
          4'd6:    byte_d = {1'b0, job_i.from_addr[20:14]};
          4'd7:    byte_d = {1'b0, job_i.from_addr[13:7]};
          4'd8:    byte_d = {1'b0, job_i.from_addr[6:0]};
          4'd9:    byte_d = {1'b0, job_i.msg_type[13:7]};
          4'd10:   byte_d = {1'b0, job_i.msg_type[6:0]};
          4'd11:   byte_d = job_i.len_byte;
          default: begin
            byte_d = CloseByte;
            eof_d  = 1'b1;
          end
        endcase
      end
      JobData: begin
        if (idx_q == 4'd0) begin
          byte_d = {1'b0, job_i.grp0};
        end else if ((idx_q == 4'd1) && job_i.two_grp) begin
          byte_d = {1'b0, job_i.grp1};
        end else begin
          byte_d = CloseByte;
          eof_d  = 1'b1;
        end
      end
      default: begin
        byte_d = '0;
        rej_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        idx_q   <= at_last ? '0 : idx_q + 4'd1;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= at_last;
      eof_q  <= eof_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign tx_byte_o      = byte_q;
  assign last_of_run_o  = last_q;
  assign end_of_frame_o = eof_q;
  assign rejected_o     = rej_q;

  a_eof_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && eof_q) |-> (byte_q == CloseByte) && last_q && !rej_q)
    else $error("end of frame without closing byte");
  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rej_q) |-> (byte_q == 8'h00) && last_q)
    else $error("rejected result malformed");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= HdrCloseIdx) else $error("sequencer index out of range");

endmodule

// ===== design/seven_bit_frame_encoder.sv =====
// Top level of the seven-bit frame encoder.
// Depends on sbfe_pkg, sbfe_front, sbfe_queue and sbfe_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one item per accepted edge. mode_i = 0 starts a
//   frame (to_address_i, message_type_i, payload_length_i); mode_i = 1 carries one payload
//   byte in data_byte_i. A start with more than 99 payload bytes, or a data item with no open
//   frame, gives one result with rejected_o set and tx_byte_o zero.
//   Output channel (out_valid_o / out_stall_i): one frame byte per item, with last_of_run_o
//   on the final byte caused by an input item and end_of_frame_o on the closing 0xFF.
//   Config: cfg_we_i writes the 28-bit local address; write it only while the block is idle.
// Timing:
//   The front end classifies an item in the cycle it is accepted and queues one job. The
//   sequencer emits one byte per cycle while out_stall_i is low. The job is written into the
//   queue, then its first byte into the output register. A start item gives 12 or 13 bytes,
//   a data item 1 to 3. Sustained input rate is one item per result run, set by the byte
//   rate; the two-entry job queue lets the input run ahead while output drains.
// Reset: clears the frame state, the local address, the queue and the output valid flag.
// Stall: when out_stall_i holds, the output byte holds; the queue fills and then in_stall_o
//   rises until the sequencer moves again.
module seven_bit_frame_encoder import sbfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [27:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [28:0] to_address_i,
  input  logic [13:0] message_type_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_frame_o,
  output logic        rejected_o
);

  logic accept;
  logic q_full, q_empty, q_pop;
  job_t job_in, job_head;

  // accept whenever the job queue has room
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  sbfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .to_address_i     (to_address_i),
    .message_type_i   (message_type_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .job_o            (job_in)
  );

  sbfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_head)
  );

  sbfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .job_i          (job_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tx_byte_o      (tx_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o),
    .rejected_o     (rejected_o)
  );

endmodule
